// ===== hdl/djs_pkg.sv =====
// Shared constants for the dependency-aware priority job scheduler.
package djs_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned IdBitsDef     = 12;
  localparam int unsigned PrioBitsDef   = 2;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_SUBMIT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd1;
  localparam logic [CMD_W-1:0] CMD_COMPLETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FLUSH    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE_READY = 2'd2;

endpackage

// ===== hdl/dependency_aware_priority_job_scheduler_core.sv =====
// Job scheduler core: job table and completion bitmap in RAMs, scan-based dispatch.
// Submit, complete, unused commands, empty dispatch, query of id 0: result in the cycle after the beat.
// Query: result registered from the bitmap RAM read in S_QUERY.
// Dispatch: S_SCAN reads each slot through the p1 and p2 registers, then S_SHIFT moves later
// jobs down when a job is ready. Flush: clears the bitmap, one word per cycle.
// Reset: busy while clearing the bitmap. Next beat at the strobe; results cannot stall.
module dependency_aware_priority_job_scheduler_core #(
  parameter int unsigned QUEUE_DEPTH   = djs_pkg::QueueDepthDef,
  parameter int unsigned ID_BITS       = djs_pkg::IdBitsDef,
  parameter int unsigned PRIORITY_BITS = djs_pkg::PrioBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [djs_pkg::CMD_W-1:0]        cmd_i,
  input  logic [PRIORITY_BITS-1:0]         priority_req_i,
  input  logic [ID_BITS-1:0]               dependency_id_i,
  input  logic [ID_BITS-1:0]               job_id_i,
  output logic                             result_valid_o,
  output logic [djs_pkg::STATUS_W-1:0]     status_o,
  output logic [ID_BITS-1:0]               result_id_o,
  output logic                             is_done_o,
  output logic                             queue_empty_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count_o
);

  import djs_pkg::*;

  localparam int unsigned IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENT_W  = 2 * ID_BITS + PRIORITY_BITS;
  localparam int unsigned ID_SPC = 2 ** ID_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QUERY = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;

  logic [2:0]               state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [ID_BITS-1:0]       next_id_q, next_id_d;
  logic [ID_BITS-1:0]       clr_q, clr_d;
  logic                     flush_q, flush_d;
  logic [CNT_W-1:0]         issue_q, issue_d;
  logic                     p1_vld_q, p1_vld_d;
  logic [IDX_W-1:0]         p1_idx_q, p1_idx_d;
  logic                     p2_vld_q, p2_vld_d;
  logic [IDX_W-1:0]         p2_idx_q, p2_idx_d;
  logic [ID_BITS-1:0]       p2_id_q, p2_id_d;
  logic [PRIORITY_BITS-1:0] p2_prio_q, p2_prio_d;
  logic                     p2_dep_zero_q, p2_dep_zero_d;
  logic                     found_q, found_d;
  logic [IDX_W-1:0]         best_idx_q, best_idx_d;
  logic [ID_BITS-1:0]       best_id_q, best_id_d;
  logic [PRIORITY_BITS-1:0] best_prio_q, best_prio_d;
  logic [CNT_W-1:0]         sh_rd_q, sh_rd_d;
  logic                     sh_vld_q, sh_vld_d;
  logic [IDX_W-1:0]         sh_widx_q, sh_widx_d;
  logic                     res_vld_q, res_vld_d;
  logic [STATUS_W-1:0]      res_status_q, res_status_d;
  logic [ID_BITS-1:0]       res_id_q, res_id_d;
  logic                     res_done_q, res_done_d;

  logic                     qram_we;
  logic [IDX_W-1:0]         qram_waddr, qram_raddr;
  logic [ENT_W-1:0]         qram_wdata, qram_rdata;
  logic                     bm_we;
  logic [ID_BITS-1:0]       bm_waddr, bm_raddr;
  logic                     bm_wdata, bm_rdata;

  logic                     accept;
  logic [ID_BITS-1:0]       nid;
  logic [ID_BITS-1:0]       rd_id, rd_dep;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [CNT_W-1:0]         last_idx;
  logic                     ready;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign {rd_id, rd_prio, rd_dep} = qram_rdata;
  assign last_idx = count_q - CNT_W'(1);
  assign ready    = p2_dep_zero_q || bm_rdata;

  always_comb begin
    nid = next_id_q + ID_BITS'(1);
    if (nid == '0) begin
      nid = ID_BITS'(1);
    end
  end

  assign qram_raddr = (state_q == S_SHIFT) ? sh_rd_q[IDX_W-1:0] : issue_q[IDX_W-1:0];
  assign bm_raddr   = (state_q == S_SCAN) ? rd_dep : job_id_i;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    next_id_d     = next_id_q;
    clr_d         = clr_q;
    flush_d       = flush_q;
    issue_d       = issue_q;
    p1_vld_d      = 1'b0;
    p1_idx_d      = p1_idx_q;
    p2_vld_d      = 1'b0;
    p2_idx_d      = p2_idx_q;
    p2_id_d       = p2_id_q;
    p2_prio_d     = p2_prio_q;
    p2_dep_zero_d = p2_dep_zero_q;
    found_d       = found_q;
    best_idx_d    = best_idx_q;
    best_id_d     = best_id_q;
    best_prio_d   = best_prio_q;
    sh_rd_d       = sh_rd_q;
    sh_vld_d      = 1'b0;
    sh_widx_d     = sh_widx_q;
    res_vld_d     = 1'b0;
    res_status_d  = res_status_q;
    res_id_d      = res_id_q;
    res_done_d    = res_done_q;
    qram_we       = 1'b0;
    qram_waddr    = count_q[IDX_W-1:0];
    qram_wdata    = {next_id_q, priority_req_i, dependency_id_i};
    bm_we         = 1'b0;
    bm_waddr      = job_id_i;
    bm_wdata      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = ST_OK;
          res_id_d     = '0;
          res_done_d   = 1'b0;
          case (cmd_i)
            CMD_SUBMIT: begin
              res_vld_d = 1'b1;
              if (count_q == CNT_W'(QUEUE_DEPTH)) begin
                res_status_d = ST_FULL;
              end else begin
                qram_we   = 1'b1;
                bm_we     = 1'b1;
                bm_waddr  = next_id_q;
                count_d   = count_q + CNT_W'(1);
                next_id_d = nid;
                res_id_d  = next_id_q;
              end
            end
            CMD_DISPATCH: begin
              if (count_q == '0) begin
                res_vld_d    = 1'b1;
                res_status_d = ST_NONE_READY;
              end else begin
                state_d = S_SCAN;
                issue_d = '0;
                found_d = 1'b0;
              end
            end
            CMD_COMPLETE: begin
              res_vld_d = 1'b1;
              if (job_id_i != '0) begin
                bm_we    = 1'b1;
                bm_wdata = 1'b1;
              end
            end
            CMD_QUERY: begin
              if (job_id_i == '0) begin
                res_vld_d  = 1'b1;
                res_done_d = 1'b1;
              end else begin
                state_d = S_QUERY;
              end
            end
            CMD_FLUSH: begin
              count_d = '0;
              clr_d   = '0;
              flush_d = 1'b1;
              state_d = S_CLEAR;
            end
            default: begin
              res_vld_d = 1'b1;
            end
          endcase
        end
      end
      S_QUERY: begin
        res_vld_d  = 1'b1;
        res_done_d = bm_rdata;
        state_d    = S_IDLE;
      end
      S_SCAN: begin
        if (issue_q < count_q) begin
          issue_d  = issue_q + CNT_W'(1);
          p1_vld_d = 1'b1;
          p1_idx_d = issue_q[IDX_W-1:0];
        end
        p2_vld_d      = p1_vld_q;
        p2_idx_d      = p1_idx_q;
        p2_id_d       = rd_id;
        p2_prio_d     = rd_prio;
        p2_dep_zero_d = (rd_dep == '0);
        if (p2_vld_q) begin
          if (ready && (!found_q || p2_prio_q > best_prio_q)) begin
            found_d     = 1'b1;
            best_idx_d  = p2_idx_q;
            best_id_d   = p2_id_q;
            best_prio_d = p2_prio_q;
          end
          if (CNT_W'(p2_idx_q) == last_idx) begin
            if (found_d) begin
              state_d = S_SHIFT;
              sh_rd_d = CNT_W'(best_idx_d) + CNT_W'(1);
            end else begin
              res_vld_d    = 1'b1;
              res_status_d = ST_NONE_READY;
              state_d      = S_IDLE;
            end
          end
        end
      end
      S_SHIFT: begin
        if (sh_rd_q < count_q) begin
          sh_rd_d   = sh_rd_q + CNT_W'(1);
          sh_vld_d  = 1'b1;
          sh_widx_d = sh_rd_q[IDX_W-1:0] - IDX_W'(1);
        end
        if (sh_vld_q) begin
          qram_we    = 1'b1;
          qram_waddr = sh_widx_q;
          qram_wdata = qram_rdata;
        end
        if (!(sh_rd_q < count_q) && !sh_vld_q) begin
          count_d   = count_q - CNT_W'(1);
          res_vld_d = 1'b1;
          res_id_d  = best_id_q;
          state_d   = S_IDLE;
        end
      end
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_q;
        clr_d    = clr_q + ID_BITS'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
          flush_d = 1'b0;
          if (flush_q) begin
            res_vld_d    = 1'b1;
            res_status_d = ST_OK;
            res_id_d     = '0;
            res_done_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      count_q   <= '0;
      next_id_q <= ID_BITS'(1);
      clr_q     <= '0;
      flush_q   <= 1'b0;
      issue_q   <= '0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      sh_rd_q   <= '0;
      sh_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      clr_q     <= clr_d;
      flush_q   <= flush_d;
      issue_q   <= issue_d;
      p1_vld_q  <= p1_vld_d;
      p2_vld_q  <= p2_vld_d;
      found_q   <= found_d;
      sh_rd_q   <= sh_rd_d;
      sh_vld_q  <= sh_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_idx_q      <= p1_idx_d;
    p2_idx_q      <= p2_idx_d;
    p2_id_q       <= p2_id_d;
    p2_prio_q     <= p2_prio_d;
    p2_dep_zero_q <= p2_dep_zero_d;
    best_idx_q    <= best_idx_d;
    best_id_q     <= best_id_d;
    best_prio_q   <= best_prio_d;
    sh_widx_q     <= sh_widx_d;
    res_status_q  <= res_status_d;
    res_id_q      <= res_id_d;
    res_done_q    <= res_done_d;
  end

  djs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (qram_we),
    .waddr_i (qram_waddr),
    .wdata_i (qram_wdata),
    .raddr_i (qram_raddr),
    .rdata_o (qram_rdata)
  );

  djs_ram #(
    .WIDTH (1),
    .DEPTH (ID_SPC)
  ) u_done_ram (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  assign result_valid_o = res_vld_q;
  assign status_o       = res_status_q;
  assign result_id_o    = res_id_q;
  assign is_done_o      = res_done_q;
  assign queue_empty_o  = (count_q == '0);
  assign queue_count_o  = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == ST_FULL) |-> (queue_count_o == CNT_W'(QUEUE_DEPTH)))
    else $error("full status with free slots");

  a_shift_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> found_q)
    else $error("compaction without a selected job");

  a_submit_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == CMD_SUBMIT || cmd_i == CMD_COMPLETE)) |=> result_valid_o)
    else $error("missing result strobe after submit or complete");

endmodule

// ===== hdl/djs_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module djs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== tb/dependency_aware_priority_job_scheduler_core_tb.sv =====
// Self-checking bench for the job scheduler core: shadow job table, directed and random beats.
`timescale 1ns / 100ps

module dependency_aware_priority_job_scheduler_core_tb;
  import djs_pkg::*;

  localparam int unsigned DEPTH       = QueueDepthDef;
  localparam int unsigned ID_W        = IdBitsDef;
  localparam int unsigned PRIO_W      = PrioBitsDef;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_WAIT  = 60;
  localparam int unsigned RAND_BEATS  = 900;

  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_FLUSH + 3'd1;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = '1;
  localparam logic [ID_W-1:0]  ID_NONE         = '0;
  localparam logic [ID_W-1:0]  ID_TOP          = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic                done;
    logic                empty;
    logic [CNT_W-1:0]    count;
  } sched_resp_t;

  class job_sched_shadow;
    logic [ID_W-1:0]   slot_id   [DEPTH];
    logic [PRIO_W-1:0] slot_prio [DEPTH];
    logic [ID_W-1:0]   slot_dep  [DEPTH];
    bit                done_bits [1 << ID_W];
    int unsigned       held;
    logic [ID_W-1:0]   next_id;
    int unsigned       errors;
    sched_resp_t       awaited_replies[$];

    function new();
      clear_all();
      next_id  = ID_W'(1);
      errors   = 0;
    endfunction

    function void clear_all();
      held = 0;
      foreach (done_bits[i]) done_bits[i] = 1'b0;
    endfunction

    function void note_command(input logic [CMD_W-1:0] cmd, input logic [PRIO_W-1:0] prio,
                               input logic [ID_W-1:0] dep, input logic [ID_W-1:0] jid);
      sched_resp_t r;
      int          best;
      bit          found;
      bit          ready;
      r = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_SUBMIT: begin
          if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            slot_id[held]      = next_id;
            slot_prio[held]    = prio;
            slot_dep[held]     = dep;
            held++;
            done_bits[next_id] = 1'b0;
            r.id               = next_id;
            next_id            = next_id + 1'b1;
            if (next_id == ID_NONE) begin
              next_id = ID_W'(1);
            end
          end
        end
        CMD_DISPATCH: begin
          found = 1'b0;
          best  = 0;
          for (int i = 0; i < held; i++) begin
            ready = (slot_dep[i] == ID_NONE) || done_bits[slot_dep[i]];
            if (ready && (!found || slot_prio[i] > slot_prio[best])) begin
              best  = i;
              found = 1'b1;
            end
          end
          if (found) begin
            r.id = slot_id[best];
            for (int i = best; i + 1 < held; i++) begin
              slot_id[i]   = slot_id[i+1];
              slot_prio[i] = slot_prio[i+1];
              slot_dep[i]  = slot_dep[i+1];
            end
            held--;
          end else begin
            r.status = ST_NONE_READY;
          end
        end
        CMD_COMPLETE: begin
          if (jid != ID_NONE) done_bits[jid] = 1'b1;
        end
        CMD_QUERY: begin
          r.done = (jid == ID_NONE) || done_bits[jid];
        end
        CMD_FLUSH: begin
          clear_all();
        end
        default: begin
        end
      endcase
      r.empty = (held == 0);
      r.count = CNT_W'(held);
      awaited_replies.insert(awaited_replies.size(), r);
    endfunction

    task report_mismatch(input string what, input int unsigned got, input int unsigned want);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
      errors++;
    endtask

    task check_response(input logic [STATUS_W-1:0] status, input logic [ID_W-1:0] id,
                        input logic done, input logic empty, input logic [CNT_W-1:0] count);
      sched_resp_t w;
      if (awaited_replies.size() == 0) begin
        report_mismatch("unexpected result beat, status", status, 0);
      end else begin
        w = awaited_replies.pop_front();
        if (status !== w.status) report_mismatch("status", status, w.status);
        if (id !== w.id) report_mismatch("result_id", id, w.id);
        if (done !== w.done) report_mismatch("is_done", done, w.done);
        if (empty !== w.empty) report_mismatch("queue_empty", empty, w.empty);
        if (count !== w.count) report_mismatch("queue_count", count, w.count);
      end
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [CMD_W-1:0]        cmd_i;
  logic [PRIO_W-1:0]       priority_req_i;
  logic [ID_W-1:0]         dependency_id_i;
  logic [ID_W-1:0]         job_id_i;
  logic                    result_valid_o;
  logic [STATUS_W-1:0]     status_o;
  logic [ID_W-1:0]         result_id_o;
  logic                    is_done_o;
  logic                    queue_empty_o;
  logic [CNT_W-1:0]        queue_count_o;

  job_sched_shadow shadow;
  int unsigned     idle_pct;
  int unsigned     stall_cycles;

  dependency_aware_priority_job_scheduler_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .priority_req_i (priority_req_i),
    .dependency_id_i(dependency_id_i),
    .job_id_i       (job_id_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .result_id_o    (result_id_o),
    .is_done_o      (is_done_o),
    .queue_empty_o  (queue_empty_o),
    .queue_count_o  (queue_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      shadow.check_response(status_o, result_id_o, is_done_o, queue_empty_o, queue_count_o);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [PRIO_W-1:0] prio,
                       input logic [ID_W-1:0] dep, input logic [ID_W-1:0] jid);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start           <= 1'b1;
    cmd_i           <= cmd;
    priority_req_i  <= prio;
    dependency_id_i <= dep;
    job_id_i        <= jid;
    do @(posedge clk_i); while (busy);
    shadow.note_command(cmd, prio, dep, jid);
  endtask

  function automatic logic [ID_W-1:0] near_id(input int unsigned span);
    near_id = shadow.next_id - ID_W'($urandom_range(span, 1));
  endfunction

  function automatic logic [ID_W-1:0] pick_target();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 7) pick_target = near_id(12);
    else if (r < 8) pick_target = ID_NONE;
    else pick_target = ID_W'($urandom());
  endfunction

  task automatic directed_sequence();
    issue(CMD_QUERY, 2'd3, ID_TOP, ID_NONE);
    issue(CMD_DISPATCH, 2'd0, ID_NONE, ID_NONE);
    issue(CMD_COMPLETE, 2'd1, ID_TOP, ID_NONE);
    issue(CMD_COMPLETE, 2'd0, ID_NONE, ID_TOP);
    issue(CMD_QUERY, 2'd0, ID_NONE, ID_TOP);
    issue(CMD_SUBMIT, 2'd0, ID_NONE, ID_TOP);
    issue(CMD_SUBMIT, 2'd3, ID_TOP, ID_NONE);
    issue(CMD_SUBMIT, 2'd3, ID_W'(20), ID_NONE);
    issue(CMD_SUBMIT, 2'd2, ID_NONE, ID_NONE);
    issue(CMD_SUBMIT, 2'd2, ID_NONE, ID_NONE);
    issue(CMD_DISPATCH, 2'd3, ID_TOP, ID_TOP);
    issue(CMD_DISPATCH, 2'd0, ID_NONE, ID_NONE);
    issue(CMD_COMPLETE, 2'd0, ID_NONE, ID_W'(20));
    issue(CMD_DISPATCH, 2'd0, ID_NONE, ID_NONE);
    issue(CMD_QUERY, 2'd0, ID_NONE, ID_W'(3));
    issue(CMD_SPARE_FIRST, 2'd3, ID_TOP, ID_TOP);
    issue(CMD_SPARE_LAST, 2'd3, ID_TOP, ID_TOP);
    issue(CMD_FLUSH, 2'd3, ID_TOP, ID_TOP);
    issue(CMD_QUERY, 2'd0, ID_NONE, ID_TOP);
    issue(CMD_SUBMIT, 2'd1, ID_TOP, ID_NONE);
    issue(CMD_DISPATCH, 2'd0, ID_NONE, ID_NONE);
    issue(CMD_COMPLETE, 2'd0, ID_NONE, ID_TOP);
    issue(CMD_DISPATCH, 2'd0, ID_NONE, ID_NONE);
  endtask

  task automatic random_command(input int unsigned sub_w, input int unsigned disp_w);
    int unsigned       r;
    logic [CMD_W-1:0]  cmd;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   dep;
    logic [ID_W-1:0]   jid;
    prio = PRIO_W'($urandom());
    dep  = ID_W'($urandom());
    jid  = ID_W'($urandom());
    r    = $urandom_range(99);
    if (r < 1) begin
      cmd = CMD_FLUSH;
    end else if (r < 3) begin
      cmd = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    end else if (r < 3 + sub_w) begin
      cmd = CMD_SUBMIT;
      r   = $urandom_range(9);
      if (r < 4) dep = ID_NONE;
      else if (r < 8) dep = near_id(8);
    end else if (r < 3 + sub_w + disp_w) begin
      cmd = CMD_DISPATCH;
    end else if ($urandom_range(4) < 3) begin
      cmd = CMD_COMPLETE;
      jid = pick_target();
    end else begin
      cmd = CMD_QUERY;
      jid = pick_target();
    end
    issue(cmd, prio, dep, jid);
  endtask

  initial begin
    int unsigned sub_w;
    int unsigned disp_w;
    shadow          = new();
    stall_cycles    = 0;
    idle_pct        = 12;
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    cmd_i           <= CMD_SUBMIT;
    priority_req_i  <= '0;
    dependency_id_i <= '0;
    job_id_i        <= '0;
    sub_w           = 35;
    disp_w          = 30;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    directed_sequence();
    for (int n = 0; n < RAND_BEATS; n++) begin
      if (n == RAND_BEATS / 3) idle_pct = 79;
      if (n == 2 * RAND_BEATS / 3) idle_pct = 0;
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: begin
            sub_w  = 35;
            disp_w = 30;
          end
          1: begin
            sub_w  = 60;
            disp_w = 10;
          end
          default: begin
            sub_w  = 15;
            disp_w = 50;
          end
        endcase
      end
      random_command(sub_w, disp_w);
    end
    start <= 1'b0;
    while (shadow.awaited_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
